>>> rtl/core/ucst_pkg.sv
// shared types and constants for the udp client session table
// no dependencies; imported by udp_client_session_table
package ucst_pkg;

    localparam logic [31:0] EXIT_WORD        = 32'h6578_6974;
    localparam logic [6:0]  UDP_HEADER_BYTES = 7'd8;
    localparam logic [6:0]  EXIT_LEN_BYTES   = 7'd4;

    typedef enum logic [2:0] {
        STAT_COUNTED   = 3'd0,
        STAT_REMOVED   = 3'd1,
        STAT_FOREIGN   = 3'd2,
        STAT_MALFORMED = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WAIT,
        S_DECIDE
    } state_t;

endpackage

>>> rtl/core/udp_client_session_table.sv
// udp client session table: header checks, slot scan, per-client counter
// depends on ucst_pkg
//
// One packet is taken when start is high and busy is low. A packet that is
// malformed or not addressed to listen_port gives its result transfer from the
// check step; any other packet gives it from the decide step, after the scan
// and wait steps, because the table memory is read one slot per cycle through a
// single 48-bit address/port comparator before the slot is chosen. The result is
// shown for one cycle with done high and cannot be held off; busy stays
// high until it is shown. listen_port is written over the cfg channel,
// which is always ready and must only be used while busy is low.
module udp_client_session_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] src_ip,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [3:0]  header_words,
    input  logic [15:0] total_length,
    input  logic [15:0] received_length,
    input  logic [31:0] payload_head,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  entry_index,
    output logic [31:0] message_count,
    output logic [31:0] reply_ip,
    output logic [15:0] reply_port
);
    import ucst_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MW = 80;

    state_t state_reg, state_next;

    logic [15:0] listen_port_reg;

    logic [31:0] ip_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;
    logic [3:0]  hwords_reg;
    logic [15:0] tot_reg;
    logic [15:0] rcv_reg;
    logic [31:0] head_reg;

    logic        is_exit_reg, is_exit_next;
    logic [IW-1:0] scan_cnt_reg, scan_cnt_next;

    logic          probe_on_reg;
    logic          probe_live_reg;
    logic [IW-1:0] probe_addr_reg;
    logic [MW-1:0] rd_data_reg;

    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]   hit_count_reg, hit_count_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    logic [TABLE_DEPTH-1:0] entry_valid_reg;
    logic [MW-1:0]          entry_mem [TABLE_DEPTH];

    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic [3:0]  index_reg, index_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] rip_reg, rip_next;
    logic [15:0] rport_reg, rport_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic          vld_we;
    logic          vld_wbit;

    logic          accept;
    logic [6:0]    hdr;
    logic          reject;
    logic [2:0]    reject_code;
    logic          probe_match;
    logic [IW-1:0] slot;
    logic [IW+3:0] slot_wide;
    logic [31:0]   base_count;
    logic [31:0]   count_inc;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign done          = done_reg;
    assign status        = status_reg;
    assign entry_index   = index_reg;
    assign message_count = count_reg;
    assign reply_ip      = rip_reg;
    assign reply_port    = rport_reg;

    assign hdr         = {1'b0, hwords_reg, 2'b00} + UDP_HEADER_BYTES;
    assign probe_match = probe_on_reg && probe_live_reg
                         && (rd_data_reg[MW-1:32] == {ip_reg, sport_reg});
    assign slot        = hit_reg ? hit_idx_reg : free_idx_reg;
    assign slot_wide   = {4'b0000, slot};
    assign base_count  = hit_reg ? hit_count_reg : 32'd0;
    assign count_inc   = base_count + 32'd1;

    always_comb
    begin
        reject      = 1'b0;
        reject_code = STAT_MALFORMED;
        if (rcv_reg < {9'd0, hdr})
        begin
            reject      = 1'b1;
            reject_code = STAT_MALFORMED;
        end
        else if (dport_reg != listen_port_reg)
        begin
            reject      = 1'b1;
            reject_code = STAT_FOREIGN;
        end
        else if (tot_reg < {9'd0, hdr})
        begin
            reject      = 1'b1;
            reject_code = STAT_MALFORMED;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = reject ? S_IDLE : S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == IW'(TABLE_DEPTH - 1))
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        is_exit_next   = is_exit_reg;
        scan_cnt_next  = scan_cnt_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_count_next = hit_count_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        rip_next       = rip_reg;
        rport_next     = rport_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot;
        mem_wdata      = {ip_reg, sport_reg, count_inc};
        vld_we         = 1'b0;
        vld_wbit       = 1'b0;

        // probe results from the registered read of the slot addressed by the scan counter
        if (probe_match && !hit_reg)
        begin
            hit_next       = 1'b1;
            hit_idx_next   = probe_addr_reg;
            hit_count_next = rd_data_reg[31:0];
        end
        if (probe_on_reg && !probe_live_reg && !free_reg)
        begin
            free_next     = 1'b1;
            free_idx_next = probe_addr_reg;
        end

        case (state_reg)
            S_CHECK:
            begin
                // exit needs 4 payload bytes announced and all 4 received
                is_exit_next  = (tot_reg == {9'd0, hdr + EXIT_LEN_BYTES})
                                && (rcv_reg >= {9'd0, hdr + EXIT_LEN_BYTES})
                                && (head_reg == EXIT_WORD);
                scan_cnt_next = '0;
                hit_next      = 1'b0;
                free_next     = 1'b0;
                if (reject)
                begin
                    done_next   = 1'b1;
                    status_next = reject_code;
                    index_next  = 4'd0;
                    count_next  = 32'd0;
                    rip_next    = 32'd0;
                    rport_next  = 16'd0;
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + IW'(1);
            end
            S_DECIDE:
            begin
                done_next = 1'b1;
                if (!hit_reg && !free_reg)
                begin
                    status_next = STAT_FULL;
                    index_next  = 4'd0;
                    count_next  = 32'd0;
                    rip_next    = 32'd0;
                    rport_next  = 16'd0;
                end
                else if (is_exit_reg)
                begin
                    vld_we      = 1'b1;
                    vld_wbit    = 1'b0;
                    status_next = STAT_REMOVED;
                    index_next  = slot_wide[3:0];
                    count_next  = 32'd0;
                    rip_next    = ip_reg;
                    rport_next  = sport_reg;
                end
                else
                begin
                    mem_we      = 1'b1;
                    vld_we      = 1'b1;
                    vld_wbit    = 1'b1;
                    status_next = STAT_COUNTED;
                    index_next  = slot_wide[3:0];
                    count_next  = count_inc;
                    rip_next    = ip_reg;
                    rport_next  = sport_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            listen_port_reg <= 16'd0;
            entry_valid_reg <= '0;
            probe_on_reg    <= 1'b0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
            done_reg        <= 1'b0;
            scan_cnt_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            probe_on_reg <= (state_reg == S_SCAN);
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            done_reg     <= done_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_valid && cfg_ready)
                listen_port_reg <= cfg_data;
            if (vld_we)
                entry_valid_reg[slot] <= vld_wbit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ip_reg     <= src_ip;
            sport_reg  <= src_port;
            dport_reg  <= dst_port;
            hwords_reg <= header_words;
            tot_reg    <= total_length;
            rcv_reg    <= received_length;
            head_reg   <= payload_head;
        end
        is_exit_reg    <= is_exit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_count_reg  <= hit_count_next;
        free_idx_reg   <= free_idx_next;
        probe_addr_reg <= scan_cnt_reg;
        probe_live_reg <= entry_valid_reg[scan_cnt_reg];
        status_reg     <= status_next;
        index_reg      <= index_next;
        count_reg      <= count_next;
        rip_reg        <= rip_next;
        rport_reg      <= rport_next;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= entry_mem[scan_cnt_reg];
    end

`ifndef ASSERT_OFF
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_CHECK || $past(state_reg) == S_DECIDE))
        else $error("result without a check or decide step");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high while result shown");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FOREIGN || status == STAT_MALFORMED
                  || status == STAT_FULL))
        |-> (entry_index == 4'd0 && message_count == 32'd0
             && reply_ip == 32'd0 && reply_port == 16'd0))
        else $error("rejected packet reports nonzero fields");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && hit_reg) |-> entry_valid_reg[hit_idx_reg])
        else $error("matched slot is not valid");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CHECK))
        else $error("accepted packet did not enter the check step");
`endif

endmodule
